/* rtl/gbs_pkg.sv */
// shared types and constants for the greedy box suppression block
// no dependencies
package gbs_pkg;

   localparam int COORD_W = 20;
   localparam int THR_W   = 16;
   localparam int OFF_W   = 5;
   localparam int LIM_W   = 9;
   localparam int INDEX_W = 12;

   typedef logic signed [COORD_W-1:0] coord_type;

   // packed so that left_x sits in the lowest bits
   typedef struct packed {
      coord_type bottom_y;
      coord_type right_x;
      coord_type top_y;
      coord_type left_x;
   } box_type;

   localparam int BOX_W = $bits(box_type);

   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_OFFSET    = 2'd1,
      CSR_MAX_KEPT  = 2'd2
   } csr_index_type;

   localparam logic [THR_W-1:0] THR_RESET = 16'd45875;
   localparam logic [OFF_W-1:0] OFF_RESET = 5'd16;
   localparam logic [LIM_W-1:0] LIM_RESET = 9'd256;

endpackage

/* rtl/gbs_ram.sv */
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module gbs_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gbs_iou.sv */
// pipelined overlap test of one stored box against the candidate box
// depends on gbs_pkg
module gbs_iou
   import gbs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  box_type          kept_box,
   input  box_type          cand_box,
   input  logic [OFF_W-1:0] offset,
   input  logic [THR_W-1:0] threshold,
   output logic             hit_valid,
   output logic             hit
);

   // stage 1: extents
   logic                     v1_ff;
   logic                     ovl1_ff, ovl1_in;
   logic        [20:0]       iw1_ff, iw1_in, ih1_ff, ih1_in;
   logic signed [21:0]       aw1_ff, aw1_in, ah1_ff, ah1_in;
   logic signed [21:0]       bw1_ff, bw1_in, bh1_ff, bh1_in;
   // stage 2: areas
   logic                     v2_ff, ovl2_ff;
   logic        [41:0]       inter2_ff;
   logic signed [43:0]       area_a2_ff, area_b2_ff;
   // stage 3: union
   logic                     v3_ff, ovl3_ff;
   logic        [41:0]       inter3_ff;
   logic signed [45:0]       uni3_ff;
   // stage 4: threshold products
   logic                     v4_ff, pos4_ff;
   logic        [41:0]       inter4_ff;
   logic        [38:0]       plo4_ff;
   logic        [37:0]       phi4_ff;
   // stage 5: compare
   logic                     v5_ff, hit5_ff, hit5_in;

   logic signed [21:0] off_s;
   logic signed [21:0] ix_lo, ix_hi, iy_lo, iy_hi;
   logic signed [21:0] iw_raw, ih_raw;
   logic [61:0]        rhs, lhs;

   always_comb begin
      off_s = 22'(signed'({1'b0, offset}));
      ovl1_in = (kept_box.left_x <= cand_box.right_x) && (kept_box.top_y <= cand_box.bottom_y)
             && (cand_box.left_x <= kept_box.right_x) && (cand_box.top_y <= kept_box.bottom_y);
      ix_lo = (kept_box.left_x > cand_box.left_x) ? 22'(kept_box.left_x) : 22'(cand_box.left_x);
      ix_hi = (kept_box.right_x < cand_box.right_x) ? 22'(kept_box.right_x)
                                                     : 22'(cand_box.right_x);
      iy_lo = (kept_box.top_y > cand_box.top_y) ? 22'(kept_box.top_y) : 22'(cand_box.top_y);
      iy_hi = (kept_box.bottom_y < cand_box.bottom_y) ? 22'(kept_box.bottom_y)
                                                       : 22'(cand_box.bottom_y);
      iw_raw = ix_hi - ix_lo + off_s;
      ih_raw = iy_hi - iy_lo + off_s;
      iw1_in = iw_raw[21] ? 21'd0 : iw_raw[20:0];
      ih1_in = ih_raw[21] ? 21'd0 : ih_raw[20:0];
      aw1_in = 22'(kept_box.right_x) - 22'(kept_box.left_x) + off_s;
      ah1_in = 22'(kept_box.bottom_y) - 22'(kept_box.top_y) + off_s;
      bw1_in = 22'(cand_box.right_x) - 22'(cand_box.left_x) + off_s;
      bh1_in = 22'(cand_box.bottom_y) - 22'(cand_box.top_y) + off_s;
      rhs = ({24'd0, phi4_ff} << 23) + {23'd0, plo4_ff};
      lhs = {20'd0, inter4_ff} << 16;
      hit5_in = pos4_ff && (lhs > rhs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      ovl1_ff    <= ovl1_in;
      iw1_ff     <= iw1_in;
      ih1_ff     <= ih1_in;
      aw1_ff     <= aw1_in;
      ah1_ff     <= ah1_in;
      bw1_ff     <= bw1_in;
      bh1_ff     <= bh1_in;
      ovl2_ff    <= ovl1_ff;
      inter2_ff  <= iw1_ff * ih1_ff;
      area_a2_ff <= aw1_ff * ah1_ff;
      area_b2_ff <= bw1_ff * bh1_ff;
      ovl3_ff    <= ovl2_ff;
      inter3_ff  <= inter2_ff;
      uni3_ff    <= 46'(area_a2_ff) + 46'(area_b2_ff) - 46'(signed'({1'b0, inter2_ff}));
      pos4_ff    <= ovl3_ff && !uni3_ff[45] && (uni3_ff != 46'sd0);
      inter4_ff  <= inter3_ff;
      plo4_ff    <= threshold * uni3_ff[22:0];
      phi4_ff    <= threshold * uni3_ff[44:23];
      hit5_ff    <= hit5_in;
   end

   assign hit_valid = v5_ff;
   assign hit       = hit5_ff;

endmodule

/* rtl/greedy_box_suppression_top.sv */
// greedy box suppression top level: control sequencer, kept box store, overlap unit
// depends on gbs_pkg, gbs_ram, gbs_iou
//
// channel  dir  handshake          payload
// req_     in   tvalid/tready      tdata = left_x, top_y, right_x, bottom_y; tlast = last_of_set
// rsp_     out  tvalid/tready      tdata = kept, box_index, kept_count; tlast = set_done
// csr_     in   valid/ready        index, data
//
// one request at a time: one stored box is read per cycle from the store into the
// five-stage overlap unit.
// reset clears counters and loads the configuration defaults; the store holds no reset state.
// a finished response waits in the output register; the next request is taken meanwhile.
module greedy_box_suppression_top
   import gbs_pkg::*;
#(
   parameter int MAX_KEPT  = 256,
   parameter int MAX_BOXES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // left_x, top_y, right_x, bottom_y
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // kept, box_index, kept_count, zero pad
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam int AW = MAX_KEPT > 1 ? $clog2(MAX_KEPT) : 1;
   localparam int PW = MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1;
   localparam int LW = CW > LIM_W ? CW : LIM_W;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type        state_ff;
   logic [THR_W-1:0] thr_ff;
   logic [OFF_W-1:0] off_ff;
   logic [LIM_W-1:0] lim_ff;
   logic [CW-1:0]    total_ff;
   logic [PW-1:0]    pos_ff;
   logic [CW-1:0]    issue_ff, result_ff;
   logic             rd_vld_ff;
   box_type          cand_ff;
   logic             last_ff, keep_ff;
   logic             rsp_valid_ff, rsp_last_ff;
   logic [23:0]      rsp_data_ff;

   logic [LW-1:0]    limit;
   logic             keep_init, rd_en, wr_en, out_free, hit_valid, hit;
   box_type          kept_box;
   logic [CW-1:0]    total_next;

   always_comb begin
      limit      = (LW'(lim_ff) > LW'(MAX_KEPT)) ? LW'(MAX_KEPT) : LW'(lim_ff);
      keep_init  = LW'(total_ff) < limit;
      rd_en      = (state_ff == ST_SCAN) && (issue_ff < total_ff);
      out_free   = !rsp_valid_ff || rsp_tready;
      wr_en      = (state_ff == ST_DONE) && out_free && keep_ff;
      total_next = total_ff + CW'(keep_ff);
   end

   gbs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_KEPT)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (total_ff[AW-1:0]),
      .wr_data (cand_ff),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (kept_box)
   );

   gbs_iou u_iou (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_vld_ff),
      .kept_box  (kept_box),
      .cand_box  (cand_ff),
      .offset    (off_ff),
      .threshold (thr_ff),
      .hit_valid (hit_valid),
      .hit       (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_RESET;
         off_ff       <= OFF_RESET;
         lim_ff       <= LIM_RESET;
         total_ff     <= '0;
         pos_ff       <= '0;
         issue_ff     <= '0;
         result_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_THRESHOLD: thr_ff <= csr_data;
               CSR_OFFSET:    off_ff <= csr_data[OFF_W-1:0];
               CSR_MAX_KEPT:  lim_ff <= csr_data[LIM_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  cand_ff   <= box_type'(req_tdata);
                  last_ff   <= req_tlast;
                  keep_ff   <= keep_init;
                  issue_ff  <= '0;
                  result_ff <= '0;
                  state_ff  <= (keep_init && total_ff != '0) ? ST_SCAN : ST_DONE;
               end
            end
            ST_SCAN: begin
               if (rd_en) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               if (hit_valid) begin
                  result_ff <= result_ff + 1'b1;
                  if (hit) begin
                     keep_ff <= 1'b0;
                  end
                  if (result_ff + 1'b1 == total_ff) begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_last_ff  <= last_ff;
                  rsp_data_ff  <= {2'b00, LIM_W'(total_next), INDEX_W'(pos_ff), keep_ff};
                  if (last_ff) begin
                     total_ff <= '0;
                     pos_ff   <= '0;
                  end else begin
                     total_ff <= total_next;
                     pos_ff   <= (pos_ff == PW'(MAX_BOXES - 1)) ? '0 : pos_ff + 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
